FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/ffsa_pkg.sv
// ----------------------------------------------------------------------------
// ffsa_pkg
// Field widths, operation codes and status codes of the segment allocator.
// ----------------------------------------------------------------------------
package ffsa_pkg;

    localparam int MODE_W   = 3;
    localparam int SLOT_W   = 5;
    localparam int LEN_W    = 11;
    localparam int WORD_W   = 32;
    localparam int ADDR_W   = 10;
    localparam int STATUS_W = 2;
    localparam int START_W  = 10;
    localparam int SIZE_W   = 11;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC   = 3'd0,
        MODE_DATA    = 3'd1,
        MODE_ALIAS   = 3'd2,
        MODE_DROP    = 3'd3,
        MODE_READ    = 3'd4,
        MODE_COLLECT = 3'd5
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_NO_MEM = 2'd1,
        ST_NO_REF = 2'd2,
        ST_RANGE  = 2'd3
    } status_t;

endpackage

FILE: design/first_fit_segment_allocator.sv
// Data word, alias, drop and unused modes give their result through the dispatch and done
// states, a read through a read state as well. An allocate or collect walks the occupancy
// memory: a search scans it for a free run, a re-mark clears it and marks the live span of
// every valid slot, a compaction moves the live words down; an allocate may take up to two
// re-marks (aliases may cover the segment once per slot).
// One item is in work at a time; the next is taken while the result waits in its register.
// Reset and every segment_size write run a clearing pass over the segment first.
// ----------------------------------------------------------------------------
// first_fit_segment_allocator
// First-fit word allocator over an occupancy bitmap, with re-mark and compaction.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module first_fit_segment_allocator
    import ffsa_pkg::*;
#(
    parameter int SEGMENT_WORDS = 1024,
    parameter int REF_SLOTS     = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  item_valid,
    output logic                  item_stall,
    input  logic [MODE_W-1:0]     mode,
    input  logic [SLOT_W-1:0]     ref_slot,
    input  logic [SLOT_W-1:0]     source_slot,
    input  logic [LEN_W-1:0]      length,
    input  logic signed [WORD_W-1:0] data_word,
    input  logic [ADDR_W-1:0]     address,

    output logic                  result_valid,
    input  logic                  result_stall,
    output logic [STATUS_W-1:0]   status,
    output logic [START_W-1:0]    start_position,
    output logic signed [WORD_W-1:0] read_word,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [SIZE_W-1:0]     segment_size
);

    // Address width of the two memories, width of a size, and one common width for
    // counts, run lengths and end positions that holds a start plus any length.
    localparam int AW  = $clog2(SEGMENT_WORDS);
    localparam int SZW = $clog2(SEGMENT_WORDS + 1);
    localparam int CW  = ((SZW > LEN_W) ? SZW : LEN_W) + 1;
    localparam int SW  = $clog2(REF_SLOTS);
    localparam int RESET_SIZE = (SEGMENT_WORDS < 1024) ? SEGMENT_WORDS : 1024;

    // The controller is a one-hot sequencer. Every long operation is a pass over the
    // occupancy memory (and the word memory for clearing and compaction), one entry per cycle.
    typedef enum logic [12:0] {
        S_CLEAR     = 13'b0000000000001,
        S_IDLE      = 13'b0000000000010,
        S_DISPATCH  = 13'b0000000000100,
        S_FF        = 13'b0000000001000,
        S_DECIDE    = 13'b0000000010000,
        S_MARK_CLR  = 13'b0000000100000,
        S_MARK_REF  = 13'b0000001000000,
        S_MARK_FILL = 13'b0000010000000,
        S_CMP       = 13'b0000100000000,
        S_CMP_TAIL  = 13'b0001000000000,
        S_COMMIT    = 13'b0010000000000,
        S_READ      = 13'b0100000000000,
        S_DONE      = 13'b1000000000000
    } state_t;

    // Reference slots are taken modulo the table depth. The slot field is narrow, so a
    // few conditional subtractions are enough.
    function automatic logic [SW-1:0] slot_of(input logic [SLOT_W-1:0] v);
        logic [SLOT_W-1:0] r;
        r = v;
        for (int n = 0; n < 8; n++) begin
            if (int'(r) >= REF_SLOTS) begin
                r = r - SLOT_W'(REF_SLOTS);
            end
        end
        return SW'(r);
    endfunction

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    state_t                  state_reg, state_next;
    logic [SZW-1:0]          ss_reg, ss_next;
    logic [CW-1:0]           idx_reg, idx_next;
    logic                    pv_reg, pv_next;
    logic [CW-1:0]           p_idx_reg, p_idx_next;
    logic [CW-1:0]           run_reg, run_next;
    logic [CW-1:0]           free_reg, free_next;
    logic [CW-1:0]           j_reg, j_next;
    logic [CW-1:0]           end_reg, end_next;
    logic [SW-1:0]           k_reg, k_next;

    logic [MODE_W-1:0]       mode_reg, mode_next;
    logic [SW-1:0]           slot_reg, slot_next;
    logic [SW-1:0]           src_reg, src_next;
    logic [LEN_W-1:0]        len_reg, len_next;
    logic [WORD_W-1:0]       word_reg, word_next;
    logic [ADDR_W-1:0]       addr_reg, addr_next;

    logic [AW-1:0]           ref_start_reg [REF_SLOTS];
    logic [AW-1:0]           ref_start_next [REF_SLOTS];
    logic [LEN_W-1:0]        ref_len_reg [REF_SLOTS];
    logic [LEN_W-1:0]        ref_len_next [REF_SLOTS];
    logic [REF_SLOTS-1:0]    ref_valid_reg, ref_valid_next;
    logic [REF_SLOTS-1:0]    moved_reg, moved_next;

    logic [AW-1:0]           cursor_reg, cursor_next;
    logic [LEN_W-1:0]        rem_reg, rem_next;

    logic                    existed_reg, existed_next;
    logic                    marked_reg, marked_next;
    logic                    dropped_reg, dropped_next;
    logic                    maycomp_reg, maycomp_next;

    status_t                 res_status_reg, res_status_next;
    logic [START_W-1:0]      res_start_reg, res_start_next;
    logic [WORD_W-1:0]       res_word_reg, res_word_next;

    logic                    oval_reg, oval_next;
    status_t                 status_reg, status_next;
    logic [START_W-1:0]      start_reg, start_next;
    logic [WORD_W-1:0]       rword_reg, rword_next;

    // ------------------------------------------------------------------------
    // Memories: one write port and one registered read port each
    // ------------------------------------------------------------------------
    logic [WORD_W-1:0]       seg_mem [SEGMENT_WORDS];
    logic                    occ_mem [SEGMENT_WORDS];

    logic                    seg_we, occ_we, occ_wd;
    logic [AW-1:0]           seg_wa, occ_wa, seg_ra, occ_ra;
    logic [WORD_W-1:0]       seg_wd, seg_q;
    logic                    occ_q;

    always_ff @(posedge clk)
    begin
        if (seg_we)
        begin
            seg_mem[seg_wa] <= seg_wd;
        end
        if (occ_we)
        begin
            occ_mem[occ_wa] <= occ_wd;
        end
        seg_q <= seg_mem[seg_ra];
        occ_q <= occ_mem[occ_ra];
    end

    // ------------------------------------------------------------------------
    // Derived values
    // ------------------------------------------------------------------------
    logic          item_take, cfg_take;
    logic [CW-1:0] ss_ext, len_ext, idx_inc, cfg_ext, addr_ext;
    logic [CW-1:0] pos, mk_start, mk_sum, mk_end, j_adv;
    logic          issue, last_p, found;
    logic [SZW-1:0] cfg_size;

    assign ss_ext   = CW'(ss_reg);
    assign len_ext  = CW'(len_reg);
    assign idx_inc  = idx_reg + CW'(1);
    assign addr_ext = CW'(addr_reg);
    assign cfg_ext  = CW'(segment_size);
    assign cfg_size = (cfg_ext == '0) ? SZW'(1)
                    : ((cfg_ext > CW'(SEGMENT_WORDS)) ? SZW'(SEGMENT_WORDS) : SZW'(cfg_ext));

    // Scan pipeline: an address goes out while the data of the previous one comes back.
    assign issue  = (idx_reg < ss_ext);
    assign last_p = pv_reg && (p_idx_reg == ss_ext - CW'(1));
    assign found  = pv_reg && !occ_q && (run_reg + CW'(1) == len_ext);
    assign pos    = p_idx_reg + CW'(1) - len_ext;
    assign j_adv  = j_reg + CW'(occ_q);

    // Live span of the reference under the re-mark pointer, cut at the segment end.
    assign mk_start = CW'(ref_start_reg[k_reg]);
    assign mk_sum   = mk_start + CW'(ref_len_reg[k_reg]);
    assign mk_end   = (mk_sum < ss_ext) ? mk_sum : ss_ext;

    // Configuration has priority over an item in the same cycle; it is taken in the
    // clearing pass too and then restarts it.
    assign cfg_ready  = (state_reg == S_IDLE) || (state_reg == S_CLEAR);
    assign cfg_take   = cfg_valid && cfg_ready;
    assign item_stall = (state_reg != S_IDLE) || cfg_valid;
    assign item_take  = item_valid && !item_stall;

    // ------------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        ss_next         = ss_reg;
        idx_next        = idx_reg;
        pv_next         = 1'b0;
        p_idx_next      = p_idx_reg;
        run_next        = run_reg;
        free_next       = free_reg;
        j_next          = j_reg;
        end_next        = end_reg;
        k_next          = k_reg;
        mode_next       = mode_reg;
        slot_next       = slot_reg;
        src_next        = src_reg;
        len_next        = len_reg;
        word_next       = word_reg;
        addr_next       = addr_reg;
        ref_start_next  = ref_start_reg;
        ref_len_next    = ref_len_reg;
        ref_valid_next  = ref_valid_reg;
        moved_next      = moved_reg;
        cursor_next     = cursor_reg;
        rem_next        = rem_reg;
        existed_next    = existed_reg;
        marked_next     = marked_reg;
        dropped_next    = dropped_reg;
        maycomp_next    = maycomp_reg;
        res_status_next = res_status_reg;
        res_start_next  = res_start_reg;
        res_word_next   = res_word_reg;
        status_next     = status_reg;
        start_next      = start_reg;
        rword_next      = rword_reg;
        oval_next       = oval_reg && result_stall;

        seg_we = 1'b0;
        seg_wa = idx_reg[AW-1:0];
        seg_wd = '0;
        seg_ra = idx_reg[AW-1:0];
        occ_we = 1'b0;
        occ_wa = idx_reg[AW-1:0];
        occ_wd = 1'b0;
        occ_ra = idx_reg[AW-1:0];

        case (state_reg)
            S_CLEAR:
            begin
                seg_we   = 1'b1;
                occ_we   = 1'b1;
                idx_next = idx_inc;
                if (idx_inc >= ss_ext)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (item_take)
                begin
                    mode_next       = mode;
                    slot_next       = slot_of(ref_slot);
                    src_next        = slot_of(source_slot);
                    len_next        = length;
                    word_next       = data_word;
                    addr_next       = address;
                    res_status_next = ST_OK;
                    res_start_next  = '0;
                    res_word_next   = '0;
                    if (mode != MODE_DATA)
                    begin
                        rem_next = '0;
                    end
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                case (mode_reg)
                    MODE_ALLOC:
                    begin
                        if (len_reg == '0)
                        begin
                            res_status_next = ST_NO_MEM;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            existed_next = ref_valid_reg[slot_reg];
                            maycomp_next = !ref_valid_reg[slot_reg];
                            marked_next  = 1'b0;
                            dropped_next = 1'b0;
                            idx_next     = '0;
                            run_next     = '0;
                            free_next    = '0;
                            state_next   = S_FF;
                        end
                    end
                    MODE_DATA:
                    begin
                        if (rem_reg != '0)
                        begin
                            seg_we      = 1'b1;
                            seg_wa      = cursor_reg;
                            seg_wd      = word_reg;
                            cursor_next = cursor_reg + AW'(1);
                            rem_next    = rem_reg - LEN_W'(1);
                        end
                        state_next = S_DONE;
                    end
                    MODE_ALIAS:
                    begin
                        if (!ref_valid_reg[src_reg])
                        begin
                            res_status_next = ST_NO_REF;
                        end
                        else
                        begin
                            ref_start_next[slot_reg] = ref_start_reg[src_reg];
                            ref_len_next[slot_reg]   = ref_len_reg[src_reg];
                            ref_valid_next[slot_reg] = 1'b1;
                        end
                        state_next = S_DONE;
                    end
                    MODE_DROP:
                    begin
                        if (!ref_valid_reg[slot_reg])
                        begin
                            res_status_next = ST_NO_REF;
                        end
                        else
                        begin
                            ref_valid_next[slot_reg] = 1'b0;
                        end
                        state_next = S_DONE;
                    end
                    MODE_READ:
                    begin
                        if (addr_ext >= ss_ext)
                        begin
                            res_status_next = ST_RANGE;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            seg_ra     = addr_ext[AW-1:0];
                            state_next = S_READ;
                        end
                    end
                    MODE_COLLECT:
                    begin
                        idx_next   = '0;
                        state_next = S_MARK_CLR;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_FF:
            begin
                if (issue)
                begin
                    idx_next   = idx_inc;
                    pv_next    = 1'b1;
                    p_idx_next = idx_reg;
                end
                if (pv_reg)
                begin
                    if (occ_q)
                    begin
                        run_next = '0;
                    end
                    else
                    begin
                        run_next  = run_reg + CW'(1);
                        free_next = free_reg + CW'(1);
                    end
                end
                if (found)
                begin
                    ref_start_next[slot_reg] = pos[AW-1:0];
                    ref_len_next[slot_reg]   = len_reg;
                    ref_valid_next[slot_reg] = 1'b1;
                    res_start_next           = pos[START_W-1:0];
                    cursor_next              = pos[AW-1:0];
                    rem_next                 = len_reg;
                    idx_next                 = pos;
                    end_next                 = pos + len_ext;
                    pv_next                  = 1'b0;
                    state_next               = S_COMMIT;
                end
                else if (last_p)
                begin
                    pv_next    = 1'b0;
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                if (!marked_reg)
                begin
                    marked_next = 1'b1;
                    idx_next    = '0;
                    state_next  = S_MARK_CLR;
                end
                else if (free_reg < len_ext)
                begin
                    res_status_next = ST_NO_MEM;
                    state_next      = S_DONE;
                end
                else if (!existed_reg && maycomp_reg)
                begin
                    idx_next   = '0;
                    j_next     = '0;
                    moved_next = '0;
                    state_next = S_CMP;
                end
                else if (!dropped_reg)
                begin
                    ref_valid_next[slot_reg] = 1'b0;
                    existed_next = 1'b0;
                    marked_next  = 1'b0;
                    dropped_next = 1'b1;
                    maycomp_next = 1'b0;
                    idx_next     = '0;
                    run_next     = '0;
                    free_next    = '0;
                    state_next   = S_FF;
                end
                else
                begin
                    res_status_next = ST_NO_MEM;
                    state_next      = S_DONE;
                end
            end

            S_MARK_CLR:
            begin
                occ_we   = 1'b1;
                idx_next = idx_inc;
                if (idx_inc >= ss_ext)
                begin
                    k_next     = '0;
                    state_next = S_MARK_REF;
                end
            end

            S_MARK_REF, S_MARK_FILL:
            begin
                if (state_reg == S_MARK_REF && ref_valid_reg[k_reg] && mk_start < mk_end)
                begin
                    idx_next   = mk_start;
                    end_next   = mk_end;
                    state_next = S_MARK_FILL;
                end
                else
                begin
                    if (state_reg == S_MARK_FILL)
                    begin
                        occ_we   = 1'b1;
                        occ_wd   = 1'b1;
                        idx_next = idx_inc;
                    end
                    if (state_reg == S_MARK_REF || idx_inc == end_reg)
                    begin
                        if (int'(k_reg) == REF_SLOTS - 1)
                        begin
                            // Re-mark finished: an allocate searches again, a collect
                            // goes on to compaction.
                            idx_next = '0;
                            if (mode_reg == MODE_ALLOC)
                            begin
                                run_next   = '0;
                                free_next  = '0;
                                state_next = S_FF;
                            end
                            else
                            begin
                                j_next     = '0;
                                moved_next = '0;
                                state_next = S_CMP;
                            end
                        end
                        else
                        begin
                            k_next     = k_reg + SW'(1);
                            state_next = S_MARK_REF;
                        end
                    end
                end
            end

            S_CMP:
            begin
                seg_ra = idx_reg[AW-1:0];
                if (issue)
                begin
                    idx_next   = idx_inc;
                    pv_next    = 1'b1;
                    p_idx_next = idx_reg;
                end
                if (pv_reg && occ_q)
                begin
                    // The write pointer never passes the read pointer, so a moved word
                    // never lands on an entry still to be read.
                    seg_we = 1'b1;
                    seg_wa = j_reg[AW-1:0];
                    seg_wd = seg_q;
                    occ_we = 1'b1;
                    occ_wa = j_reg[AW-1:0];
                    occ_wd = 1'b1;
                    for (int k = 0; k < REF_SLOTS; k++)
                    begin
                        if (ref_valid_reg[k] && !moved_reg[k]
                            && CW'(ref_start_reg[k]) == p_idx_reg)
                        begin
                            ref_start_next[k] = j_reg[AW-1:0];
                            moved_next[k]     = 1'b1;
                        end
                    end
                    j_next = j_adv;
                end
                if (last_p)
                begin
                    pv_next = 1'b0;
                    if (j_adv < ss_ext)
                    begin
                        idx_next   = j_adv;
                        state_next = S_CMP_TAIL;
                    end
                    else if (mode_reg == MODE_ALLOC)
                    begin
                        idx_next   = '0;
                        run_next   = '0;
                        free_next  = '0;
                        state_next = S_FF;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_CMP_TAIL:
            begin
                seg_we   = 1'b1;
                occ_we   = 1'b1;
                idx_next = idx_inc;
                if (idx_inc >= ss_ext)
                begin
                    if (mode_reg == MODE_ALLOC)
                    begin
                        idx_next   = '0;
                        run_next   = '0;
                        free_next  = '0;
                        state_next = S_FF;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_COMMIT:
            begin
                occ_we   = 1'b1;
                occ_wd   = 1'b1;
                idx_next = idx_inc;
                if (idx_inc == end_reg)
                begin
                    state_next = S_DONE;
                end
            end

            S_READ:
            begin
                res_word_next = seg_q;
                state_next    = S_DONE;
            end

            S_DONE:
            begin
                if (!oval_reg || !result_stall)
                begin
                    status_next = res_status_reg;
                    start_next  = res_start_reg;
                    rword_next  = res_word_reg;
                    oval_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A size write empties every reference and the fill, then clears the memories.
        if (cfg_take)
        begin
            ss_next        = cfg_size;
            ref_valid_next = '0;
            cursor_next    = '0;
            rem_next       = '0;
            idx_next       = '0;
            state_next     = S_CLEAR;
        end
    end

    // ------------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            ss_reg        <= SZW'(RESET_SIZE);
            idx_reg       <= '0;
            pv_reg        <= 1'b0;
            ref_valid_reg <= '0;
            cursor_reg    <= '0;
            rem_reg       <= '0;
            existed_reg   <= 1'b0;
            marked_reg    <= 1'b0;
            dropped_reg   <= 1'b0;
            maycomp_reg   <= 1'b0;
            oval_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ss_reg        <= ss_next;
            idx_reg       <= idx_next;
            pv_reg        <= pv_next;
            ref_valid_reg <= ref_valid_next;
            cursor_reg    <= cursor_next;
            rem_reg       <= rem_next;
            existed_reg   <= existed_next;
            marked_reg    <= marked_next;
            dropped_reg   <= dropped_next;
            maycomp_reg   <= maycomp_next;
            oval_reg      <= oval_next;
        end
    end

    // ------------------------------------------------------------------------
    // Payload and work registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        p_idx_reg      <= p_idx_next;
        run_reg        <= run_next;
        free_reg       <= free_next;
        j_reg          <= j_next;
        end_reg        <= end_next;
        k_reg          <= k_next;
        mode_reg       <= mode_next;
        slot_reg       <= slot_next;
        src_reg        <= src_next;
        len_reg        <= len_next;
        word_reg       <= word_next;
        addr_reg       <= addr_next;
        ref_start_reg  <= ref_start_next;
        ref_len_reg    <= ref_len_next;
        moved_reg      <= moved_next;
        res_status_reg <= res_status_next;
        res_start_reg  <= res_start_next;
        res_word_reg   <= res_word_next;
        status_reg     <= status_next;
        start_reg      <= start_next;
        rword_reg      <= rword_next;
    end

    assign result_valid   = oval_reg;
    assign status         = status_reg;
    assign start_position = start_reg;
    assign read_word      = rword_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `ASSERT_IMPL(a_cmp_order, state_reg == S_CMP && pv_reg, j_reg <= p_idx_reg, "compaction write passed read")
    `ASSERT_IMPL(a_fill_bound, rem_reg != '0, CW'(cursor_reg) + CW'(rem_reg) <= ss_ext, "fill run leaves segment")
    `ASSERT_IMPL(a_result_src, $rose(oval_reg), $past(state_reg == S_DONE), "result without completion")
    `ASSERT_NEXT(a_cfg_clear, cfg_take, state_reg == S_CLEAR && idx_reg == '0, "size write did not clear")

endmodule

FILE: tb/first_fit_checker.sv
// ----------------------------------------------------------------------------
// first_fit_checker
// Watches the item, result and size channels of the segment allocator. It
// keeps its own copy of the segment and reference table and checks every result.
// ----------------------------------------------------------------------------
module first_fit_checker
    import ffsa_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    input  logic                     item_stall,
    input  logic [MODE_W-1:0]        mode,
    input  logic [SLOT_W-1:0]        ref_slot,
    input  logic [SLOT_W-1:0]        source_slot,
    input  logic [LEN_W-1:0]         length,
    input  logic signed [WORD_W-1:0] data_word,
    input  logic [ADDR_W-1:0]        address,
    input  logic                     result_valid,
    input  logic                     result_stall,
    input  logic [STATUS_W-1:0]      status,
    input  logic [START_W-1:0]       start_position,
    input  logic signed [WORD_W-1:0] read_word,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [SIZE_W-1:0]        segment_size,
    output int                       error_count,
    output int                       awaiting
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORDS = 1024;
    localparam int SLOTS = 32;
    localparam int MAX_TRIES = 8;

    typedef struct packed {
        status_t                  st;
        logic [START_W-1:0]       start;
        logic signed [WORD_W-1:0] word;
    } answer_t;

    logic [WORD_W-1:0] words_q [WORDS];
    bit                busy_q  [WORDS];
    int unsigned       base_q  [SLOTS];
    int unsigned       span_q  [SLOTS];
    bit                live_q  [SLOTS];
    int unsigned       cursor_q;
    int unsigned       left_q;
    int unsigned       size_q;
    answer_t           answers_q[$];

    function automatic void wipe_segment();
        for (int i = 0; i < WORDS; i++)
        begin
            words_q[i] = '0;
            busy_q[i] = 1'b0;
        end
        for (int k = 0; k < SLOTS; k++)
        begin
            base_q[k] = 0;
            span_q[k] = 0;
            live_q[k] = 1'b0;
        end
        cursor_q = 0;
        left_q = 0;
    endfunction

    // First free run of the given length, or -1.
    function automatic int find_run(int unsigned len);
        int unsigned run;
        run = 0;
        for (int unsigned i = 0; i < size_q; i++)
        begin
            if (busy_q[i])
                run = 0;
            else
            begin
                run++;
                if (run == len)
                    return int'(i + 1 - len);
            end
        end
        return -1;
    endfunction

    function automatic void remark_live();
        int unsigned stop;
        for (int i = 0; i < WORDS; i++)
            busy_q[i] = 1'b0;
        for (int k = 0; k < SLOTS; k++)
        begin
            if (live_q[k])
            begin
                stop = base_q[k] + span_q[k];
                for (int unsigned i = base_q[k]; i < stop && i < size_q; i++)
                    busy_q[i] = 1'b1;
            end
        end
    endfunction

    function automatic void squeeze();
        bit          moved[SLOTS];
        int unsigned j;
        j = 0;
        for (int k = 0; k < SLOTS; k++)
            moved[k] = 1'b0;
        for (int unsigned i = 0; i < size_q; i++)
        begin
            if (busy_q[i])
            begin
                words_q[j] = words_q[i];
                for (int k = 0; k < SLOTS; k++)
                begin
                    if (live_q[k] && !moved[k] && base_q[k] == i)
                    begin
                        base_q[k] = j;
                        moved[k] = 1'b1;
                    end
                end
                j++;
            end
        end
        for (int unsigned i = 0; i < WORDS; i++)
        begin
            busy_q[i] = (i < j);
            if (i >= j)
                words_q[i] = '0;
        end
    endfunction

    function automatic int unsigned free_words();
        int unsigned n;
        n = 0;
        for (int unsigned i = 0; i < size_q; i++)
            if (!busy_q[i])
                n++;
        return n;
    endfunction

    // Allocate with re-mark, compaction or drop of the old reference on failure.
    function automatic int place_run(int unsigned slot, int unsigned len);
        bit had;
        bit marked;
        bit dropped;
        bit may_squeeze;
        int pos;
        had = live_q[slot];
        marked = 1'b0;
        dropped = 1'b0;
        may_squeeze = !had;
        for (int t = 0; t < MAX_TRIES; t++)
        begin
            pos = find_run(len);
            if (pos >= 0)
            begin
                base_q[slot] = pos;
                span_q[slot] = len;
                live_q[slot] = 1'b1;
                for (int unsigned i = 0; i < len; i++)
                    busy_q[pos + i] = 1'b1;
                return pos;
            end
            if (!marked)
            begin
                remark_live();
                marked = 1'b1;
            end
            else
            begin
                if (free_words() < len)
                    return -1;
                if (!had && may_squeeze)
                    squeeze();
                else if (!dropped)
                begin
                    live_q[slot] = 1'b0;
                    had = 1'b0;
                    marked = 1'b0;
                    dropped = 1'b1;
                    may_squeeze = 1'b0;
                end
                else
                    return -1;
            end
        end
        return -1;
    endfunction

    function automatic answer_t predict_answer();
        answer_t     a;
        int          pos;
        int unsigned slot;
        int unsigned src;
        int unsigned len;
        slot = ref_slot;
        src = source_slot;
        len = length;
        a.st = ST_OK;
        a.start = '0;
        a.word = '0;
        if (mode != MODE_DATA)
            left_q = 0;
        case (mode)
            MODE_ALLOC:
            begin
                pos = (len == 0) ? -1 : place_run(slot, len);
                if (pos < 0)
                    a.st = ST_NO_MEM;
                else
                begin
                    a.start = pos[START_W-1:0];
                    cursor_q = pos;
                    left_q = len;
                end
            end
            MODE_DATA:
            begin
                if (left_q != 0 && cursor_q < WORDS)
                begin
                    words_q[cursor_q] = data_word;
                    cursor_q++;
                    left_q--;
                end
            end
            MODE_ALIAS:
            begin
                if (!live_q[src])
                    a.st = ST_NO_REF;
                else
                begin
                    base_q[slot] = base_q[src];
                    span_q[slot] = span_q[src];
                    live_q[slot] = 1'b1;
                end
            end
            MODE_DROP:
            begin
                if (!live_q[slot])
                    a.st = ST_NO_REF;
                else
                    live_q[slot] = 1'b0;
            end
            MODE_READ:
            begin
                if (address >= size_q)
                    a.st = ST_RANGE;
                else
                    a.word = words_q[address];
            end
            MODE_COLLECT:
            begin
                remark_live();
                squeeze();
            end
            default: ;
        endcase
        return a;
    endfunction

    assign awaiting = answers_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        if (!rst_n)
        begin
            wipe_segment();
            size_q = WORDS;
            answers_q.delete();
            error_count <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (segment_size == 0)
                    size_q = 1;
                else if (segment_size > WORDS)
                    size_q = WORDS;
                else
                    size_q = segment_size;
                wipe_segment();
            end
            if (result_valid && !result_stall)
            begin
                if (answers_q.size() == 0)
                begin
                    $display("%0t: result transfer with none expected: status %0d start %0d word %0d",
                             $time, status, start_position, read_word);
                    error_count <= error_count + 1;
                end
                else
                begin
                    want = answers_q.pop_front();
                    if (status !== want.st || start_position !== want.start
                        || read_word !== want.word)
                    begin
                        $display("%0t: mismatch expected status %0d start %0d word %0d",
                                 $time, want.st, want.start, want.word);
                        $display("%0t:          actual   status %0d start %0d word %0d",
                                 $time, status, start_position, read_word);
                        error_count <= error_count + 1;
                    end
                end
            end
            if (item_valid && !item_stall)
                answers_q.push_back(predict_answer());
        end
    end
endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the segment allocator with directed and random items over several
// segment sizes, with random idling on both channels, and reports the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import ffsa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Modes six and seven are unused by the block; they must answer ok.
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;
    // Cycles without any transfer before the run is declared hung. A worst
    // case allocate walks the bitmap several times over a full segment, and
    // with aliases each re-mark may cover the segment once per slot.
    localparam int HANG_LIMIT = 1000000;

    logic                     clk;
    logic                     rst_n;
    logic                     item_valid;
    logic                     item_stall;
    logic [MODE_W-1:0]        mode;
    logic [SLOT_W-1:0]        ref_slot;
    logic [SLOT_W-1:0]        source_slot;
    logic [LEN_W-1:0]         length;
    logic signed [WORD_W-1:0] data_word;
    logic [ADDR_W-1:0]        address;
    logic                     result_valid;
    logic                     result_stall;
    logic [STATUS_W-1:0]      status;
    logic [START_W-1:0]       start_position;
    logic signed [WORD_W-1:0] read_word;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [SIZE_W-1:0]        segment_size;
    int                       error_count;
    int                       awaiting;
    int                       idle_pct;
    int                       hang_count;
    int                       items_sent;
    int                       sizes_tried;

    first_fit_segment_allocator u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .mode           (mode),
        .ref_slot       (ref_slot),
        .source_slot    (source_slot),
        .length         (length),
        .data_word      (data_word),
        .address        (address),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .status         (status),
        .start_position (start_position),
        .read_word      (read_word),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .segment_size   (segment_size)
    );

    first_fit_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .mode           (mode),
        .ref_slot       (ref_slot),
        .source_slot    (source_slot),
        .length         (length),
        .data_word      (data_word),
        .address        (address),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .status         (status),
        .start_position (start_position),
        .read_word      (read_word),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .segment_size   (segment_size),
        .error_count    (error_count),
        .awaiting       (awaiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // The result side stalls in random bursts while idling is enabled.
    initial
    begin
        int n;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
            begin
                n = $urandom_range(1, 17);
                result_stall <= 1'b1;
                repeat (n) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    // Watchdog: any transfer on any channel counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
            hang_count <= 0;
        else
            hang_count <= hang_count + 1;
        if (hang_count >= HANG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, HANG_LIMIT);
            $display("testbench: errors");
            $finish;
        end
    end

    // Offers one item and returns at the edge where it is taken. Valid is
    // left high, so the next call can follow back to back; a gap lowers it.
    task automatic send_item(input logic [MODE_W-1:0] m, input int slot, input int src,
                             input int len, input logic [WORD_W-1:0] w, input int addr);
        int n;
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            n = $urandom_range(1, 17);
            item_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        item_valid  <= 1'b1;
        mode        <= m;
        ref_slot    <= slot[SLOT_W-1:0];
        source_slot <= src[SLOT_W-1:0];
        length      <= len[LEN_W-1:0];
        data_word   <= w;
        address     <= addr[ADDR_W-1:0];
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // The size register is only written once every result has come back.
    task automatic write_size(input logic [SIZE_W-1:0] value);
        item_valid <= 1'b0;
        @(posedge clk);
        while (awaiting != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid    <= 1'b1;
        segment_size <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sizes_tried++;
    endtask

    // A well-formed allocate followed by its fill, sometimes cut short.
    task automatic alloc_and_fill(input int seg);
        int len;
        int count;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2047)
                                          : $urandom_range(1, (seg < 6) ? seg : 6);
        send_item(MODE_ALLOC, $urandom_range(0, 7), $urandom, len, $urandom, $urandom);
        count = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : len;
        if (count > 8)
            count = 8;
        for (int i = 0; i < count; i++)
            send_item(MODE_DATA, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic random_items(input int seg, input int ops);
        int pick;
        for (int i = 0; i < ops; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                alloc_and_fill(seg);
            else if (pick < 58)
                send_item(MODE_READ, $urandom, $urandom, $urandom, $urandom,
                          ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, seg - 1));
            else if (pick < 70)
                send_item(MODE_ALIAS, $urandom_range(0, 31), $urandom_range(0, 31),
                          $urandom, $urandom, $urandom);
            else if (pick < 82)
                send_item(MODE_DROP, $urandom_range(0, 31), $urandom, $urandom,
                          $urandom, $urandom);
            else if (pick < 90)
                send_item(MODE_COLLECT, $urandom, $urandom, $urandom, $urandom, $urandom);
            else if (pick < 95)
                send_item($urandom_range(0, 1) ? MODE_SPARE_LO : MODE_SPARE_HI,
                          $urandom, $urandom, $urandom, $urandom, $urandom);
            else
                send_item(MODE_DATA, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    initial
    begin
        logic [SIZE_W-1:0] sizes[6];
        int                segs[6];
        sizes = '{11'd0, 11'd2047, 11'd48, 11'd1, 11'd23, 11'd1024};
        segs  = '{1, 1024, 48, 1, 23, 1024};
        rst_n        <= 1'b0;
        item_valid   <= 1'b0;
        mode         <= MODE_READ;
        ref_slot     <= '0;
        source_slot  <= '0;
        length       <= '0;
        data_word    <= '0;
        address      <= '0;
        cfg_valid    <= 1'b0;
        segment_size <= '0;
        idle_pct     = 0;
        items_sent   = 0;
        sizes_tried  = 1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part on the full segment left by reset.
        send_item(MODE_ALLOC, 3, 0, 0, 0, 0);               // zero length
        send_item(MODE_DATA, 0, 0, 0, 32'h1234_5678, 0);    // word with no run open
        send_item(MODE_ALLOC, 31, 0, 1024, 0, 0);           // the whole segment
        send_item(MODE_DATA, 0, 0, 0, 32'h7FFF_FFFF, 0);
        send_item(MODE_DATA, 0, 0, 0, 32'h8000_0000, 0);
        send_item(MODE_DATA, 0, 0, 0, 32'hFFFF_FFFF, 0);
        send_item(MODE_READ, 0, 0, 0, 0, 1);                 // cuts the fill short
        send_item(MODE_READ, 0, 0, 0, 0, 1023);
        send_item(MODE_ALIAS, 0, 31, 0, 0, 0);
        send_item(MODE_ALIAS, 1, 5, 0, 0, 0);               // source never allocated
        send_item(MODE_DROP, 31, 0, 0, 0, 0);
        send_item(MODE_DROP, 31, 0, 0, 0, 0);               // already dropped
        send_item(MODE_ALLOC, 2, 0, 4, 0, 0);               // alias still holds it all
        send_item(MODE_DROP, 0, 0, 0, 0, 0);
        send_item(MODE_ALLOC, 0, 0, 2047, 0, 0);            // larger than any segment
        send_item(MODE_ALLOC, 2, 0, 8, 0, 0);               // re-mark frees the words
        send_item(MODE_DATA, 0, 0, 0, 32'h0000_0001, 0);
        send_item(MODE_ALLOC, 2, 0, 8, 0, 0);               // existing slot re-placed
        send_item(MODE_COLLECT, 0, 0, 0, 0, 0);
        send_item(MODE_READ, 0, 0, 0, 0, 0);
        send_item(MODE_SPARE_LO, 0, 0, 0, 0, 0);
        send_item(MODE_SPARE_HI, 31, 31, 2047, 32'hFFFF_FFFF, 1023);

        // Random part across the size settings. The last setting runs
        // without idling; one in the middle runs without idling as well.
        for (int p = 0; p < 6; p++)
        begin
            write_size(sizes[p]);
            idle_pct = (p == 3 || p == 5) ? 0 : $urandom_range(10, 35);
            random_items(segs[p], (segs[p] == 1024) ? 7 : 10);
        end
        item_valid <= 1'b0;

        while (awaiting != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        $display("Sent %0d items over %0d segment sizes, including clamped sizes,", items_sent,
                 sizes_tried);
        $display("compaction, re-marking, aliasing and out-of-range reads.");
        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+design
design/ffsa_pkg.sv
design/first_fit_segment_allocator.sv
tb/first_fit_checker.sv
tb/testbench.sv
